// ----- hdl/tcc_pkg.sv -----
// Package with the word types and fixed constants of the text console cursor writer.
`timescale 1ns / 1ps
package tcc_pkg;

    localparam int SCREEN_COLUMNS = 80;
    localparam int ADDR_FULL_W    = 12;

    localparam logic [6:0] WIN_LEFT   = 7'd3;
    localparam logic [6:0] WIN_RIGHT  = 7'd75;
    localparam logic [4:0] WIN_TOP    = 5'd3;
    localparam logic [4:0] WIN_BOTTOM = 5'd20;

    localparam logic [7:0] CODE_BACKSPACE = 8'd14;
    localparam logic [7:0] CODE_NEWLINE   = 8'd10;

    localparam logic KIND_CHAR = 1'b0;
    localparam logic KIND_READ = 1'b1;

    typedef struct packed {
        logic       kind;
        logic [7:0] char_code;
        logic [6:0] read_col;
        logic [4:0] read_row;
    } t_in_item;

    typedef struct packed {
        logic [6:0] cursor_col;
        logic [4:0] cursor_row;
        logic [7:0] read_char;
        logic       line_submitted;
        logic       screen_cleared;
    } t_out_item;

endpackage

// ----- hdl/tcc_if.sv -----
// Handshake interfaces for the input and result channels.
`timescale 1ns / 1ps
interface tcc_in_if;
    logic              valid;
    logic              ready;
    tcc_pkg::t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface tcc_out_if;
    logic               valid;
    logic               ready;
    tcc_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- hdl/text_console_cursor_writer_core.sv -----
// Top level of the text console cursor writer: character store, cursor and sequencer.
//
//  Channel  Port   Direction  Word
//  input    i_in   sink       kind, char_code, read_col, read_row
//  result   o_out  source     cursor_col, cursor_row, read_char, line_submitted,
//                             screen_cleared
//
// A typed character, newline or backspace within a row is carried out in S_EXEC,
// which registers its result; a read also passes S_RDOUT to take the registered
// store data. A backspace to the previous row scans that row through the single
// store read port, passing S_SCAN and S_SCHK for each column. A window clear
// writes one cell a cycle, 1314 cells in all. After reset the store is cleared
// one cell a cycle, 80 x SCREEN_ROWS cells, before the first word is accepted.
// A word is accepted only when the sequencer is idle and the previous result has been taken.
`timescale 1ns / 1ps
module text_console_cursor_writer_core #(
    parameter int SCREEN_ROWS = 25
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    tcc_in_if.sink           i_in,
    tcc_out_if.source        o_out
);

    localparam int DEPTH = tcc_pkg::SCREEN_COLUMNS * SCREEN_ROWS;
    localparam int AW    = $clog2(DEPTH);

    typedef enum logic [6:0] {
        S_INIT  = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_EXEC  = 7'b0000100,
        S_RDOUT = 7'b0001000,
        S_SCAN  = 7'b0010000,
        S_SCHK  = 7'b0100000,
        S_WCLR  = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    logic [AW-1:0] r_init, n_init;
    logic [6:0] r_ccol, n_ccol;
    logic [4:0] r_crow, n_crow;
    logic r_ovalid, n_ovalid;

    logic [6:0] r_pcol, n_pcol;
    logic [4:0] r_prow, n_prow;
    logic r_kind, n_kind;
    logic [7:0] r_code, n_code;
    logic r_inrange, n_inrange;
    logic r_sub, n_sub;
    tcc_pkg::t_out_item r_out, n_out;

    logic [7:0] mem [DEPTH];
    logic [7:0] r_rdata;

    logic [tcc_pkg::ADDR_FULL_W-1:0] a_full;
    logic [AW-1:0] a_ptr;
    logic          w_en;
    logic [AW-1:0] w_addr;
    logic [7:0]    w_data;
    logic          emit;
    logic          clr_done;
    logic [7:0]    e_read;
    logic          in_acc;

    assign a_full = ({1'b0, r_prow, 6'b0} + {3'b0, r_prow, 4'b0})
                  + {5'b0, r_pcol};
    assign a_ptr  = a_full[AW-1:0];

    assign i_in.ready  = (r_state == S_IDLE) && !r_ovalid;
    assign in_acc      = i_in.valid && i_in.ready;
    assign o_out.valid = r_ovalid;
    assign o_out.data  = r_out;

    always_comb begin
        n_state   = r_state;
        n_init    = r_init;
        n_ccol    = r_ccol;
        n_crow    = r_crow;
        n_ovalid  = r_ovalid;
        n_pcol    = r_pcol;
        n_prow    = r_prow;
        n_kind    = r_kind;
        n_code    = r_code;
        n_inrange = r_inrange;
        n_sub     = r_sub;
        n_out     = r_out;
        w_en      = 1'b0;
        w_addr    = a_ptr;
        w_data    = 8'd0;
        emit      = 1'b0;
        clr_done  = 1'b0;
        e_read    = 8'd0;

        if (r_ovalid && o_out.ready) begin
            n_ovalid = 1'b0;
        end

        unique case (r_state)
            S_INIT: begin
                w_en   = 1'b1;
                w_addr = r_init;
                if (r_init == AW'(DEPTH - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_init = r_init + AW'(1);
                end
            end
            S_IDLE: begin
                if (in_acc) begin
                    n_kind    = i_in.data.kind;
                    n_code    = i_in.data.char_code;
                    n_inrange = (i_in.data.read_col < 7'(tcc_pkg::SCREEN_COLUMNS))
                             && ({1'b0, i_in.data.read_row} < 6'(SCREEN_ROWS));
                    n_sub     = 1'b0;
                    n_pcol    = (i_in.data.kind == tcc_pkg::KIND_READ)
                              ? i_in.data.read_col : r_ccol;
                    n_prow    = (i_in.data.kind == tcc_pkg::KIND_READ)
                              ? i_in.data.read_row : r_crow;
                    n_state   = S_EXEC;
                end
            end
            S_EXEC: begin
                if (r_kind == tcc_pkg::KIND_READ) begin
                    n_state = S_RDOUT;
                end else if (r_code == tcc_pkg::CODE_BACKSPACE) begin
                    if (r_ccol != tcc_pkg::WIN_LEFT) begin
                        w_en   = 1'b1;
                        n_ccol = r_ccol - 7'd1;
                        emit   = 1'b1;
                    end else if (r_crow != tcc_pkg::WIN_TOP) begin
                        w_en    = 1'b1;
                        n_crow  = r_crow - 5'd1;
                        n_prow  = r_crow - 5'd1;
                        n_pcol  = tcc_pkg::WIN_RIGHT;
                        n_state = S_SCAN;
                    end else begin
                        emit = 1'b1;
                    end
                end else if (r_code == tcc_pkg::CODE_NEWLINE) begin
                    n_sub  = 1'b1;
                    n_ccol = tcc_pkg::WIN_LEFT;
                    if (r_crow == tcc_pkg::WIN_BOTTOM) begin
                        n_pcol  = tcc_pkg::WIN_LEFT;
                        n_prow  = tcc_pkg::WIN_TOP;
                        n_state = S_WCLR;
                    end else begin
                        n_crow = r_crow + 5'd1;
                        emit   = 1'b1;
                    end
                end else begin
                    w_en   = 1'b1;
                    w_data = r_code;
                    if (r_ccol == tcc_pkg::WIN_RIGHT) begin
                        if (r_crow == tcc_pkg::WIN_BOTTOM) begin
                            n_pcol  = tcc_pkg::WIN_LEFT;
                            n_prow  = tcc_pkg::WIN_TOP;
                            n_state = S_WCLR;
                        end else begin
                            n_ccol = tcc_pkg::WIN_LEFT;
                            n_crow = r_crow + 5'd1;
                            emit   = 1'b1;
                        end
                    end else begin
                        n_ccol = r_ccol + 7'd1;
                        emit   = 1'b1;
                    end
                end
            end
            S_RDOUT: begin
                e_read = r_inrange ? r_rdata : 8'd0;
                emit   = 1'b1;
            end
            S_SCAN: begin
                n_state = S_SCHK;
            end
            S_SCHK: begin
                if (r_rdata != 8'd0) begin
                    if (r_pcol == tcc_pkg::WIN_RIGHT) begin
                        n_ccol = tcc_pkg::WIN_RIGHT;
                    end else if (r_pcol == tcc_pkg::WIN_RIGHT - 7'd1) begin
                        n_ccol = tcc_pkg::WIN_RIGHT - 7'd2;
                    end else begin
                        n_ccol = r_pcol + 7'd1;
                    end
                    emit = 1'b1;
                end else if (r_pcol == tcc_pkg::WIN_LEFT + 7'd1) begin
                    n_ccol = tcc_pkg::WIN_LEFT + 7'd2;
                    emit   = 1'b1;
                end else begin
                    n_pcol  = r_pcol - 7'd1;
                    n_state = S_SCAN;
                end
            end
            S_WCLR: begin
                w_en = 1'b1;
                if (r_pcol == tcc_pkg::WIN_RIGHT) begin
                    if (r_prow == tcc_pkg::WIN_BOTTOM) begin
                        n_ccol   = tcc_pkg::WIN_LEFT;
                        n_crow   = tcc_pkg::WIN_TOP;
                        clr_done = 1'b1;
                        emit     = 1'b1;
                    end else begin
                        n_pcol = tcc_pkg::WIN_LEFT;
                        n_prow = r_prow + 5'd1;
                    end
                end else begin
                    n_pcol = r_pcol + 7'd1;
                end
            end
            default: begin
                n_state = S_INIT;
            end
        endcase

        if (emit) begin
            n_state                  = S_IDLE;
            n_ovalid                 = 1'b1;
            n_out.cursor_col         = n_ccol;
            n_out.cursor_row         = n_crow;
            n_out.read_char          = e_read;
            n_out.line_submitted     = n_sub;
            n_out.screen_cleared     = clr_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_INIT;
            r_init   <= '0;
            r_ccol   <= tcc_pkg::WIN_LEFT;
            r_crow   <= tcc_pkg::WIN_TOP;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_init   <= n_init;
            r_ccol   <= n_ccol;
            r_crow   <= n_crow;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pcol    <= n_pcol;
        r_prow    <= n_prow;
        r_kind    <= n_kind;
        r_code    <= n_code;
        r_inrange <= n_inrange;
        r_sub     <= n_sub;
        r_out     <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            mem[w_addr] <= w_data;
        end
        r_rdata <= mem[a_ptr];
    end

endmodule
